[hw/rtl/jaa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick axis autorange package
// Shared widths, register indexes, axis codes and the result saturation
// function for the joystick axis autorange unit.
// ----------------------------------------------------------------------------
package jaa_pkg;

   localparam int AXIS_BITS    = 2;
   localparam int LEVEL_BITS   = 16;
   localparam int Q_BITS       = 16;
   localparam int K_SHIFT      = 15;
   localparam int CSR_IDX_BITS = 2;

   typedef logic [AXIS_BITS-1:0] axis_type;

   localparam axis_type AXIS_X        = 2'd0;
   localparam axis_type AXIS_Y        = 2'd1;
   localparam axis_type AXIS_Z        = 2'd2;
   localparam axis_type AXIS_THROTTLE = 2'd3;

   localparam int THROTTLE_AXIS = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_X       = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_Y       = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CENTER_Z       = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_THROTTLE_START = 2'd3;

   localparam logic signed [LEVEL_BITS-1:0] POS_LEVEL = 16'sh7FFF;
   localparam logic signed [LEVEL_BITS-1:0] NEG_LEVEL = 16'sh8000;

   typedef struct packed {
      logic neg;
      logic force_zero;
      logic force_full;
   } leg_flags_type;

   // Turns the unsigned quotient magnitude into the saturated signed level.
   function automatic logic signed [LEVEL_BITS-1:0] leg_level(
      input logic [Q_BITS-1:0] q,
      input leg_flags_type     f
   );
      logic signed [LEVEL_BITS-1:0] r;
      if (f.force_zero) begin
         r = '0;
      end else if (f.force_full) begin
         r = f.neg ? NEG_LEVEL : POS_LEVEL;
      end else if (!f.neg) begin
         r = q[Q_BITS-1] ? POS_LEVEL : $signed(LEVEL_BITS'(q));
      end else begin
         r = q[Q_BITS-1] ? NEG_LEVEL : $signed(LEVEL_BITS'(~q + 1'b1));
      end
      return r;
   endfunction

endpackage

[hw/rtl/jaa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick axis autorange channels
// Valid/ready channel interfaces for the sample requests and the results.
// ----------------------------------------------------------------------------
interface jaa_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    axis;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, axis, sample, input ready);
   modport sink (input valid, axis, sample, output ready);
endinterface

interface jaa_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         axis_out;
   logic signed [15:0] level;

   modport source (output valid, axis_out, level, input ready);
   modport sink (input valid, axis_out, level, output ready);
endinterface

[hw/rtl/jaa_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick axis autorange front end
// Holds the centre registers and per-axis extremes, updates the extremes for a
// request and prepares the dividend, divisor and flags of the scaling leg.
// ----------------------------------------------------------------------------
module jaa_front #(
   parameter int NUM_AXES    = 4,
   parameter int SAMPLE_BITS = 16,
   localparam int XW         = SAMPLE_BITS + 2,
   localparam int NW         = XW + jaa_pkg::K_SHIFT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [jaa_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [SAMPLE_BITS-1:0]              csr_data,
   input  logic                                start,
   input  jaa_pkg::axis_type                   axis,
   input  logic signed [SAMPLE_BITS-1:0]       sample,
   output logic                                done,
   output logic [NW-1:0]                       numer,
   output logic [XW-1:0]                       divisor,
   output jaa_pkg::leg_flags_type              flags
);
   import jaa_pkg::*;

   localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
   localparam logic [AW-1:0] T_IDX = AW'(THROTTLE_AXIS);

   typedef enum logic [5:0] {
      F_IDLE = 6'b000001,
      F_EXT  = 6'b000010,
      F_HALF = 6'b000100,
      F_SIGN = 6'b001000,
      F_MAG  = 6'b010000,
      F_NUM  = 6'b100000
   } front_state_type;

   front_state_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] center_ff [3];
   logic signed [SAMPLE_BITS-1:0] center_in [3];
   logic signed [XW-1:0]          lo_ff [NUM_AXES];
   logic signed [XW-1:0]          lo_in [NUM_AXES];
   logic signed [XW-1:0]          hi_ff [NUM_AXES];
   logic signed [XW-1:0]          hi_in [NUM_AXES];

   axis_type                      axis_ff, axis_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [XW-1:0]          v_ff, v_in;
   logic signed [XW-1:0]          lo_s_ff, lo_s_in;
   logic signed [XW-1:0]          hi_s_ff, hi_s_in;
   logic signed [XW-1:0]          half_ff, half_in;
   logic signed [XW-1:0]          vlo_ff, vlo_in;
   logic signed [XW-1:0]          val_ff, val_in;
   logic signed [XW-1:0]          div_ff, div_in;
   logic [XW-1:0]                 mag_ff, mag_in;
   logic [NW-1:0]                 numer_ff, numer_in;
   logic                          thr_ff, thr_in;
   logic                          rng_ff, rng_in;
   logic                          neg_ff, neg_in;
   logic                          zero_ff, zero_in;
   logic                          full_ff, full_in;
   logic                          done_ff, done_in;

   logic signed [SAMPLE_BITS-1:0] cen;
   logic signed [XW-1:0]          v_new;
   logic signed [XW-1:0]          cur_lo;
   logic signed [XW-1:0]          cur_hi;
   logic signed [XW-1:0]          new_lo;
   logic signed [XW-1:0]          new_hi;
   logic [AW-1:0]                 idx;
   logic                          in_rng;
   logic                          is_thr;

   always_comb begin
      case (axis_ff)
         AXIS_Y:  cen = center_ff[1];
         AXIS_Z:  cen = center_ff[2];
         default: cen = center_ff[0];
      endcase
      is_thr = (axis_ff == AXIS_THROTTLE);
      in_rng = (int'(axis_ff) < NUM_AXES);
      idx    = AW'(axis_ff);
      cur_lo = lo_ff[idx];
      cur_hi = hi_ff[idx];
      v_new  = is_thr ? XW'(sample_ff) : XW'(sample_ff) - XW'(cen);
      new_lo = (v_new < cur_lo) ? v_new : cur_lo;
      new_hi = (v_new > cur_hi) ? v_new : cur_hi;
   end

   always_comb begin
      state_in  = state_ff;
      center_in = center_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      axis_in   = axis_ff;
      sample_in = sample_ff;
      v_in      = v_ff;
      lo_s_in   = lo_s_ff;
      hi_s_in   = hi_s_ff;
      half_in   = half_ff;
      vlo_in    = vlo_ff;
      val_in    = val_ff;
      div_in    = div_ff;
      mag_in    = mag_ff;
      numer_in  = numer_ff;
      thr_in    = thr_ff;
      rng_in    = rng_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      full_in   = full_ff;
      done_in   = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X: center_in[0] = $signed(csr_data);
            CSR_CENTER_Y: center_in[1] = $signed(csr_data);
            CSR_CENTER_Z: center_in[2] = $signed(csr_data);
            CSR_THROTTLE_START: begin
               if (NUM_AXES > THROTTLE_AXIS) begin
                  lo_in[T_IDX] = XW'($signed(csr_data));
                  hi_in[T_IDX] = XW'($signed(csr_data));
               end
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         F_IDLE: begin
            if (start) begin
               axis_in   = axis;
               sample_in = sample;
               state_in  = F_EXT;
            end
         end
         F_EXT: begin
            if (in_rng) begin
               lo_in[idx] = new_lo;
               hi_in[idx] = new_hi;
            end
            v_in     = v_new;
            lo_s_in  = new_lo;
            hi_s_in  = new_hi;
            thr_in   = is_thr;
            rng_in   = in_rng;
            state_in = F_HALF;
         end
         F_HALF: begin
            half_in  = (hi_s_ff - lo_s_ff) >>> 1;
            vlo_in   = v_ff - lo_s_ff;
            state_in = F_SIGN;
         end
         F_SIGN: begin
            val_in = thr_ff ? (vlo_ff - half_ff) : v_ff;
            if (thr_ff) begin
               div_in = half_ff;
            end else if (v_ff > 0) begin
               div_in = hi_s_ff;
            end else begin
               div_in = -lo_s_ff;
            end
            state_in = F_MAG;
         end
         F_MAG: begin
            neg_in   = val_ff[XW-1];
            mag_in   = val_ff[XW-1] ? XW'(-val_ff) : XW'(val_ff);
            zero_in  = !rng_ff || (val_ff == '0);
            full_in  = div_ff[XW-1] || (div_ff == '0);
            state_in = F_NUM;
         end
         F_NUM: begin
            numer_in = {mag_ff, {K_SHIFT{1'b0}}} - (neg_ff ? '0 : NW'(mag_ff));
            done_in  = 1'b1;
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         done_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            center_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_AXES; i++) begin
            lo_ff[i] <= '0;
            hi_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         done_ff   <= done_in;
         center_ff <= center_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff   <= axis_in;
      sample_ff <= sample_in;
      v_ff      <= v_in;
      lo_s_ff   <= lo_s_in;
      hi_s_ff   <= hi_s_in;
      half_ff   <= half_in;
      vlo_ff    <= vlo_in;
      val_ff    <= val_in;
      div_ff    <= div_in;
      mag_ff    <= mag_in;
      numer_ff  <= numer_in;
      thr_ff    <= thr_in;
      rng_ff    <= rng_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      full_ff   <= full_in;
   end

   assign done             = done_ff;
   assign numer            = numer_ff;
   assign divisor          = XW'(div_ff);
   assign flags.neg        = neg_ff;
   assign flags.force_zero = zero_ff;
   assign flags.force_full = full_ff;

endmodule

[hw/rtl/jaa_serial_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick axis autorange bit-serial divider
// Restoring divider that shifts the dividend through one bit per cycle and
// collects one quotient bit per cycle, then saturates the signed level.
// ----------------------------------------------------------------------------
module jaa_serial_div #(
   parameter int XW  = 18,
   localparam int NW = XW + jaa_pkg::K_SHIFT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [NW-1:0]                        numer,
   input  logic [XW-1:0]                        divisor,
   input  jaa_pkg::leg_flags_type               flags,
   output logic                                 done,
   output logic signed [jaa_pkg::LEVEL_BITS-1:0] level
);
   import jaa_pkg::*;

   localparam int CW = $clog2(Q_BITS);

   logic [XW:0]                   rem_ff, rem_in;
   logic [Q_BITS-1:0]             quo_ff, quo_in;
   logic [XW-1:0]                 d_ff, d_in;
   leg_flags_type                 flags_ff, flags_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic signed [LEVEL_BITS-1:0]  level_ff, level_in;

   logic [XW:0]   shifted;
   logic [XW+1:0] trial;
   logic          ge;

   always_comb begin
      shifted = {rem_ff[XW-1:0], quo_ff[Q_BITS-1]};
      trial   = {1'b0, shifted} - {2'b00, d_ff};
      ge      = !trial[XW+1];

      rem_in   = rem_ff;
      quo_in   = quo_ff;
      d_in     = d_ff;
      flags_in = flags_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      level_in = level_ff;
      done_in  = 1'b0;

      if (start) begin
         rem_in   = (XW+1)'(numer[NW-1:Q_BITS]);
         quo_in   = numer[Q_BITS-1:0];
         d_in     = divisor;
         flags_in = flags;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial[XW:0] : shifted;
         quo_in = {quo_ff[Q_BITS-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(Q_BITS - 1)) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            level_in = leg_level({quo_ff[Q_BITS-2:0], ge}, flags_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      d_ff     <= d_in;
      flags_ff <= flags_in;
      cnt_ff   <= cnt_in;
      level_ff <= level_in;
   end

   assign done  = done_ff;
   assign level = level_ff;

endmodule

[hw/rtl/joystick_axis_autorange_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick axis autorange unit
// Tracks the running extremes of four joystick axes and returns each sample
// as a normalised signed 16-bit level, scaled by a bit-serial divider.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake      Payload
//  req      in         valid/ready    axis, sample
//  rsp      out        valid/ready    axis_out, level
//  csr      in         write enable   csr_index, csr_data
//
// A request is accepted only while the unit is idle, so a further request is
// taken only after the last result is loaded into the result register.
// The steps in order are range tracking and leg preparation in the front
// end, the divider load, the bit-serial division, the divider's registered
// level and the load of the result register.
// Reset is synchronous and clears the centres and all extremes to zero.
// A stalled result is held in the output register; the unit finishes the
// request already taken and then waits for that register to drain.
// ----------------------------------------------------------------------------
module joystick_axis_autorange_unit #(
   parameter int NUM_AXES    = 4,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [jaa_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [SAMPLE_BITS-1:0]           csr_data,
   jaa_req_if.sink                          req,
   jaa_rsp_if.source                        rsp
);
   import jaa_pkg::*;

   localparam int XW = SAMPLE_BITS + 2;
   localparam int NW = XW + K_SHIFT;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FRONT = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_OUT   = 4'b1000
   } unit_state_type;

   unit_state_type state_ff, state_in;

   axis_type                     axis_ff, axis_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   axis_type                     rsp_axis_ff, rsp_axis_in;
   logic signed [LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;

   logic                         accept;
   logic                         front_done;
   logic [NW-1:0]                numer;
   logic [XW-1:0]                divisor;
   leg_flags_type                flags;
   logic                         div_done;
   logic signed [LEVEL_BITS-1:0] div_level;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;

   jaa_front #(
      .NUM_AXES    (NUM_AXES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .start     (accept),
      .axis      (req.axis),
      .sample    (req.sample),
      .done      (front_done),
      .numer     (numer),
      .divisor   (divisor),
      .flags     (flags)
   );

   jaa_serial_div #(
      .XW (XW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (front_done),
      .numer   (numer),
      .divisor (divisor),
      .flags   (flags),
      .done    (div_done),
      .level   (div_level)
   );

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_axis_in  = rsp_axis_ff;
      rsp_level_in = rsp_level_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               axis_in  = req.axis;
               state_in = ST_FRONT;
            end
         end
         ST_FRONT: begin
            if (front_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_axis_in  = axis_ff;
               rsp_level_in = div_level;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_ff      <= axis_in;
      rsp_axis_ff  <= rsp_axis_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.axis_out = rsp_axis_ff;
   assign rsp.level    = rsp_level_ff;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick axis autorange unit testbench
// Sends axis samples through the request channel under random gaps and
// result stalls, and checks every normalised level against an in-bench
// predictor of the running extremes and the two scaling legs. A short
// directed part covers the rest position, sample and centre extremes, the
// zero throttle divisor and the odd throttle range. Random rounds then
// sweep the centre and throttle start settings.
// ----------------------------------------------------------------------------
module tb;
   import jaa_pkg::*;

   localparam int     LIMIT_CYCLES = 400000;
   localparam int     DRAIN_CYCLES = 40;
   localparam int     ROUNDS       = 16;
   localparam int     ROUND_ITEMS  = 25;
   localparam longint POS_FULL     = 32767;
   localparam longint NEG_FULL     = 32768;

   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

   typedef struct {
      axis_type                     axis;
      logic signed [LEVEL_BITS-1:0] level;
   } level_entry_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [15:0]             csr_data;

   jaa_req_if #(.SAMPLE_BITS(16)) req ();
   jaa_rsp_if rsp ();

   joystick_axis_autorange_unit #(
      .NUM_AXES(4),
      .SAMPLE_BITS(16)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req(req),
      .rsp(rsp)
   );

   longint          centre [3];
   longint          throttle_start;
   longint          low_ext [4];
   longint          high_ext [4];
   level_entry_type pending_levels [$];
   level_entry_type head;
   int              errors;
   int              cycles;
   int              ready_hold;
   bit              calm;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic longint scale_leg(longint value, longint divisor);
      longint q;
      if (value == 0) begin
         return 0;
      end
      if (divisor <= 0) begin
         return (value > 0) ? POS_FULL : -NEG_FULL;
      end
      if (value > 0) begin
         q = value * POS_FULL / divisor;
         return (q > POS_FULL) ? POS_FULL : q;
      end
      q = (-value) * NEG_FULL / divisor;
      return (q > NEG_FULL) ? -NEG_FULL : -q;
   endfunction

   // Updates the running extremes of the axis and returns its level.
   function automatic logic signed [LEVEL_BITS-1:0] normalise(
      axis_type                a,
      logic signed [15:0]      s
   );
      longint v;
      longint half;
      longint lvl;
      v   = s;
      lvl = 0;
      if (a != AXIS_THROTTLE) begin
         v = v - centre[a];
      end
      if (v < low_ext[a]) begin
         low_ext[a] = v;
      end
      if (v > high_ext[a]) begin
         high_ext[a] = v;
      end
      if (a == AXIS_THROTTLE) begin
         half = (high_ext[a] - low_ext[a]) / 2;
         v    = v - low_ext[a] - half;
         lvl  = scale_leg(v, half);
      end else if (v > 0) begin
         lvl = scale_leg(v, high_ext[a]);
      end else if (v < 0) begin
         lvl = scale_leg(v, -low_ext[a]);
      end
      return lvl[LEVEL_BITS-1:0];
   endfunction

   task automatic send_sample(axis_type a, logic signed [15:0] s);
      int gap;
      level_entry_type e;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid  <= 1'b1;
      req.axis   <= a;
      req.sample <= s;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      e.axis  = a;
      e.level = normalise(a, s);
      pending_levels.push_back(e);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_BITS-1:0] idx, logic signed [15:0] value);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_THROTTLE_START: begin
            throttle_start          = value;
            low_ext[THROTTLE_AXIS]  = value;
            high_ext[THROTTLE_AXIS] = value;
         end
         default: begin
            centre[idx] = value;
         end
      endcase
   endtask

   function automatic logic signed [15:0] random_sample();
      logic signed [15:0] raw;
      raw = 16'($urandom);
      if ($urandom_range(0, 4) == 0) begin
         return raw;
      end
      return raw >>> $urandom_range(0, 15);
   endfunction

   task automatic test_rest_position();
      send_sample(AXIS_X, 16'sd0);
      send_sample(AXIS_Y, 16'sd0);
      send_sample(AXIS_Z, 16'sd0);
      send_sample(AXIS_THROTTLE, 16'sd0);
   endtask

   task automatic test_centre_extremes();
      send_sample(AXIS_X, SAMPLE_MAX);
      send_sample(AXIS_X, SAMPLE_MIN);
      send_sample(AXIS_X, -16'sd16384);
      send_sample(AXIS_Y, 16'sd1);
      send_sample(AXIS_Y, -16'sd1);
      write_register(CSR_CENTER_Z, SAMPLE_MIN);
      send_sample(AXIS_Z, SAMPLE_MAX);
      write_register(CSR_CENTER_Z, SAMPLE_MAX);
      send_sample(AXIS_Z, SAMPLE_MIN);
      send_sample(AXIS_Z, SAMPLE_MAX);
      write_register(CSR_CENTER_X, 16'sd100);
      send_sample(AXIS_X, 16'sd100);
      send_sample(AXIS_X, 16'sd50);
      write_register(CSR_CENTER_Y, -16'sd1);
      send_sample(AXIS_Y, -16'sd1);
   endtask

   task automatic test_throttle_legs();
      // Range one gives a zero half range; any nonzero offset is full scale.
      write_register(CSR_THROTTLE_START, 16'sd100);
      send_sample(AXIS_THROTTLE, 16'sd101);
      send_sample(AXIS_THROTTLE, 16'sd100);
      // With an odd range the positive leg exceeds the half range.
      write_register(CSR_THROTTLE_START, 16'sd0);
      send_sample(AXIS_THROTTLE, 16'sd3);
      send_sample(AXIS_THROTTLE, 16'sd0);
      write_register(CSR_THROTTLE_START, SAMPLE_MIN);
      send_sample(AXIS_THROTTLE, SAMPLE_MAX);
      send_sample(AXIS_THROTTLE, SAMPLE_MIN);
      send_sample(AXIS_THROTTLE, 16'sd0);
   endtask

   task automatic test_random_rounds();
      axis_type           a;
      logic signed [15:0] s;
      logic signed [15:0] start;
      for (int r = 0; r < ROUNDS; r++) begin
         wait_idle();
         calm = (r % 5 == 2);
         if (r % 4 == 0) begin
            case ((r / 4) % 4)
               0: begin
                  write_register(CSR_CENTER_X, 16'sd0);
                  write_register(CSR_CENTER_Y, 16'sd0);
                  write_register(CSR_CENTER_Z, 16'sd0);
               end
               1: begin
                  write_register(CSR_CENTER_X, SAMPLE_MAX);
                  write_register(CSR_CENTER_Y, SAMPLE_MIN);
                  write_register(CSR_CENTER_Z, SAMPLE_MAX);
               end
               2: begin
                  write_register(CSR_CENTER_X, SAMPLE_MIN);
                  write_register(CSR_CENTER_Y, SAMPLE_MAX);
                  write_register(CSR_CENTER_Z, SAMPLE_MIN);
               end
               default: begin
                  write_register(CSR_CENTER_X, random_sample());
                  write_register(CSR_CENTER_Y, random_sample());
                  write_register(CSR_CENTER_Z, random_sample());
               end
            endcase
         end
         if (r % 3 == 0) begin
            start = ((r / 3) % 2 == 0) ? SAMPLE_MIN : SAMPLE_MAX;
         end else begin
            start = random_sample();
         end
         write_register(CSR_THROTTLE_START, start);
         for (int i = 0; i < ROUND_ITEMS; i++) begin
            a = axis_type'($urandom_range(0, 3));
            s = random_sample();
            if ($urandom_range(0, 3) != 0) begin
               if (a == AXIS_THROTTLE) begin
                  s = s + 16'(throttle_start);
               end else begin
                  s = s + 16'(centre[a]);
               end
            end
            send_sample(a, s);
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      req.valid  = 1'b0;
      req.axis   = '0;
      req.sample = '0;
      rsp.ready  = 1'b0;
      errors     = 0;
      calm       = 1'b0;
      ready_hold = 0;
      throttle_start = 0;
      for (int i = 0; i < 3; i++) begin
         centre[i] = 0;
      end
      for (int i = 0; i < 4; i++) begin
         low_ext[i]  = 0;
         high_ext[i] = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_rest_position();
      test_centre_extremes();
      test_throttle_legs();
      test_random_rounds();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (ready_hold > 0) begin
         rsp.ready  <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else begin
         rsp.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            ready_hold <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready) begin
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected result axis_out %0d level %0d",
                     $time, rsp.axis_out, rsp.level);
            errors++;
         end else begin
            head = pending_levels.pop_front();
            if (rsp.axis_out !== head.axis) begin
               $display("%0t: axis_out mismatch, expected %0d, actual %0d",
                        $time, head.axis, rsp.axis_out);
               errors++;
            end
            if (rsp.level !== head.level) begin
               $display("%0t: level mismatch on axis %0d, expected %0d, actual %0d",
                        $time, head.axis, head.level, rsp.level);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("%0t: run timed out with %0d results outstanding",
                  $time, pending_levels.size());
         $display("FAIL");
         $finish;
      end
   end

endmodule

[filelist.f]
hw/rtl/jaa_pkg.sv
hw/rtl/jaa_if.sv
hw/rtl/jaa_front.sv
hw/rtl/jaa_serial_div.sv
hw/rtl/joystick_axis_autorange_unit.sv
tb/tb.sv
